// ----- rtl/hddwr_pkg.sv -----
// hddwr_pkg: shared types and constants for the hash-driven draw core
// no dependencies
`default_nettype none
package hddwr_pkg;
  localparam int MAX_POOL = 4096;
  localparam int AW = $clog2(MAX_POOL);
  localparam int CW = AW + 1;
  localparam int MW = 32;
  localparam int MAW = $clog2(MAX_POOL / MW);
  localparam int MDEPTH = MAX_POOL / MW;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       begin_selection;
    logic       last_of_digest;
  } in_word_t;

  typedef struct packed {
    logic [12:0] member;
    logic [11:0] draw_index;
    logic        final_draw;
    logic [1:0]  status;
  } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/hash_driven_draw_without_replacement_core.sv -----
// hash_driven_draw_without_replacement_core: top level of the draw core
// depends on hddwr_pkg
`default_nettype none
// Digest bytes arrive one word at a time. Each byte folds into the running
// remainder modulo the free count by a restoring divider, one compare-subtract
// step a cycle over nine steps. The free map is a 128 x 32 bit synchronous
// memory; on the last byte the core reads it row by row, through a wait state
// and a scan state per row, counting free members with a popcount, until the
// row holding the wanted rank, then finds the bit in that row bit by bit and
// writes the row back. A begin word first sweeps the map rows, one row a
// cycle. So a plain byte passes idle, the nine divide steps and the pick
// before the next word is accepted, a last byte also the row scan, the bit
// steps and the output state, and a begin word adds the sweep. A last byte
// also waits while an earlier draw word is held at the output. After reset a
// fill pass over all map rows runs before the first word is taken.
module hash_driven_draw_without_replacement_core
  import hddwr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_word_t    in_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  output out_word_t        out_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  typedef enum logic [3:0] {
    S_FILL, S_IDLE, S_CLEAR, S_DIV, S_PICK, S_SCAN, S_SCANW, S_BIT, S_OUT
  } state_t;

  state_t state;
  logic [12:0] pool_size, draw_count;
  logic [CW-1:0] free_count, draws_done;
  logic [AW-1:0] rem;
  logic [AW+8-1:0] dividend;
  logic [3:0] step;
  in_word_t cur;
  logic [MAW:0] row;
  logic [MAW-1:0] rd_row;
  logic [AW-1:0] rank;
  logic [4:0] bitpos;
  logic [MW-1:0] row_data;
  out_word_t res;

  // free map memory
  logic [MW-1:0] fmap [MDEPTH];
  logic [MW-1:0] rdata;
  logic          we;
  logic [MAW-1:0] waddr;
  logic [MW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) fmap[waddr] <= wdata;
    rdata <= fmap[rd_row];
  end

  // clamped pool size and draw count (combinational)
  logic [CW-1:0] pool, dcount;
  assign pool = (pool_size > 13'(MAX_POOL)) ? CW'(MAX_POOL) : CW'(pool_size);
  assign dcount = (draw_count > 13'(MAX_POOL)) ? CW'(MAX_POOL) : CW'(draw_count);

  // apb port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0: prdata = {19'd0, pool_size};
      default: prdata = {19'd0, draw_count};
    endcase
  end

  // fill row value for a given row under the current pool
  function automatic logic [MW-1:0] fill_row(input logic [MAW-1:0] r,
                                             input logic [CW-1:0] p);
    logic [MW-1:0] v;
    for (int i = 0; i < MW; i++)
      v[i] = ({1'b0, r, 5'(i)} < p);
    return v;
  endfunction

  function automatic logic [5:0] popc(input logic [MW-1:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < MW; i++) c = c + 6'(v[i]);
    return c;
  endfunction

  logic [5:0] pc;
  assign pc = popc(rdata);

  // restoring divide step
  logic [AW+8+1:0] sub;
  assign sub = {2'b0, free_count} << step;

  logic beyond;
  assign beyond = (draws_done >= dcount);

  assign in_stall = (state != S_IDLE);
  assign out_data = res;
  assign rd_row = row[MAW-1:0];

  always_comb begin
    we = 1'b0;
    waddr = row[MAW-1:0];
    wdata = '0;
    case (state)
      S_FILL, S_CLEAR: begin
        we = 1'b1;
        wdata = (state == S_FILL) ? '1 : fill_row(row[MAW-1:0], pool);
      end
      S_BIT: if (row_data[bitpos] && rank == '0) begin
        we = 1'b1;
        wdata = row_data & ~(MW'(1) << bitpos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      row <= '0;
      pool_size <= 13'd1;
      draw_count <= 13'd1;
      free_count <= CW'(1);
      draws_done <= '0;
      rem <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          1'b0: pool_size <= pwdata[12:0];
          default: draw_count <= pwdata[12:0];
        endcase
      end
      case (state)
        S_FILL: begin
          if (row[MAW-1:0] == MAW'(MDEPTH - 1)) begin
            row <= '0;
            state <= S_IDLE;
          end else row <= row + 1'b1;
        end
        S_IDLE: if (in_valid) begin
          cur <= in_data;
          row <= '0;
          if (in_data.begin_selection) begin
            free_count <= pool;
            draws_done <= '0;
            rem <= '0;
            state <= S_CLEAR;
          end else begin
            dividend <= {rem, in_data.digest_byte};
            step <= 4'd8;
            state <= S_DIV;
          end
        end
        S_CLEAR: begin
          if (row[MAW-1:0] == MAW'(MDEPTH - 1)) begin
            row <= '0;
            dividend <= {AW'(0), cur.digest_byte};
            step <= 4'd8;
            state <= S_DIV;
          end else row <= row + 1'b1;
        end
        S_DIV: begin
          if (free_count == '0) begin
            dividend <= '0;
            state <= S_PICK;
          end else begin
            if ({2'b0, dividend} >= sub) dividend <= dividend - (AW+8)'(sub);
            if (step == 4'd0) state <= S_PICK;
            else step <= step - 1'b1;
          end
        end
        S_PICK: begin
          if (!cur.last_of_digest) begin
            rem <= dividend[AW-1:0];
            state <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            res.draw_index <= draws_done[11:0];
            res.final_draw <= (dcount != '0) && (draws_done == dcount - 1'b1);
            res.member <= '0;
            rem <= '0;
            if (beyond) begin
              res.status <= ST_BEYOND;
              state <= S_OUT;
            end else begin
              draws_done <= draws_done + 1'b1;
              res.status <= ST_EMPTY;
              if (free_count == '0) state <= S_OUT;
              else begin
                rank <= dividend[AW-1:0];
                row <= '0;
                state <= S_SCANW;
              end
            end
          end
        end
        S_SCANW: state <= S_SCAN;
        S_SCAN: begin
          if ({1'b0, rank} < {{AW-5{1'b0}}, pc}) begin
            row_data <= rdata;
            bitpos <= '0;
            state <= S_BIT;
          end else begin
            rank <= rank - AW'(pc);
            row <= row + 1'b1;
            if (row[MAW-1:0] == MAW'(MDEPTH - 1)) state <= S_OUT;
            else state <= S_SCANW;
          end
        end
        S_BIT: begin
          bitpos <= bitpos + 1'b1;
          if (row_data[bitpos]) begin
            if (rank == '0) begin
              res.member <= 13'({row[MAW-1:0], bitpos}) + 13'd1;
              res.status <= ST_OK;
              free_count <= free_count - 1'b1;
              state <= S_OUT;
            end else rank <= rank - 1'b1;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
